// ===== design/fac_pkg.sv =====
// Shared constants and types for the frustum box culling pipeline.
`default_nettype none

package fac_pkg;

    // Packed plane word layout: nx, ny, nz in the low bits, offset d on top.
    localparam int PLANE_WIDTH   = 64;
    localparam int NORMAL_WIDTH  = 12;
    localparam int OFFSET_WIDTH  = 28;
    localparam int OFFSET_LSB    = 3 * NORMAL_WIDTH;

    // The offset is Q.8 and the products are Q.18, so d is aligned by ten bits.
    localparam int OFFSET_SHIFT  = 10;

    // Number of writable plane registers and the width of their index.
    localparam int REG_COUNT       = 6;
    localparam int CFG_INDEX_WIDTH = 3;

    // Defaults for the top-level parameters.
    localparam int PLANE_COUNT_DEF = 6;
    localparam int COORD_WIDTH_DEF = 24;
    localparam int INDEX_WIDTH_DEF = 16;

    // Per-box flags carried along the cell chain.
    typedef struct packed {
        logic last;
        logic vis;
    } fac_flags_t;

endpackage : fac_pkg

`default_nettype wire

// ===== design/fac_cell.sv =====
// One plane-test cell: products in the first stage, sum and sign test in the second.
`default_nettype none

module fac_cell
    import fac_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [PLANE_WIDTH-1:0]     plane,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [3*COORD_WIDTH-1:0]   in_lo,
    input  wire logic [3*COORD_WIDTH-1:0]   in_hi,
    input  wire fac_flags_t                 in_flags,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [3*COORD_WIDTH-1:0]        out_lo,
    output logic [3*COORD_WIDTH-1:0]        out_hi,
    output fac_flags_t                      out_flags
);

    localparam int PROD_WIDTH  = COORD_WIDTH + NORMAL_WIDTH;
    localparam int OFFSET_SPAN = OFFSET_WIDTH + OFFSET_SHIFT;
    localparam int SUM_WIDTH   = ((PROD_WIDTH > OFFSET_SPAN) ? PROD_WIDTH : OFFSET_SPAN) + 2;

    logic signed [PROD_WIDTH-1:0]   prod_next [3];
    logic signed [PROD_WIDTH-1:0]   a_prod_reg [3];
    logic [3*COORD_WIDTH-1:0]       a_lo_reg;
    logic [3*COORD_WIDTH-1:0]       a_hi_reg;
    fac_flags_t                     a_flags_reg;
    logic                           a_valid_reg;
    logic                           a_ready;

    logic [3*COORD_WIDTH-1:0]       b_lo_reg;
    logic [3*COORD_WIDTH-1:0]       b_hi_reg;
    fac_flags_t                     b_flags_reg;
    fac_flags_t                     b_flags_next;
    logic                           b_valid_reg;
    logic                           b_ready;

    logic signed [OFFSET_WIDTH-1:0] offset;
    logic signed [SUM_WIDTH-1:0]    plane_sum;

    // Handshake: each stage takes a new beat when it is empty or its beat moves on.
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // Positive vertex: a negative normal component picks min, otherwise max.
    // The doubled test collapses to n * vertex on each axis.
    always_comb
    begin
        logic signed [NORMAL_WIDTH-1:0] nrm;
        logic signed [COORD_WIDTH-1:0]  vtx;
        for (int a = 0; a < 3; a++)
        begin
            nrm = plane[a*NORMAL_WIDTH +: NORMAL_WIDTH];
            vtx = nrm[NORMAL_WIDTH-1] ? in_lo[a*COORD_WIDTH +: COORD_WIDTH]
                                      : in_hi[a*COORD_WIDTH +: COORD_WIDTH];
            prod_next[a] = PROD_WIDTH'(nrm) * PROD_WIDTH'(vtx);
        end
    end

    // Product stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            for (int a = 0; a < 3; a++)
            begin
                a_prod_reg[a] <= prod_next[a];
            end
            a_lo_reg    <= in_lo;
            a_hi_reg    <= in_hi;
            a_flags_reg <= in_flags;
        end
    end

    // Sum with the aligned offset; a negative sum culls the box.
    assign offset = plane[OFFSET_LSB +: OFFSET_WIDTH];

    always_comb
    begin
        plane_sum = (SUM_WIDTH'(offset) <<< OFFSET_SHIFT)
                  + SUM_WIDTH'(a_prod_reg[0])
                  + SUM_WIDTH'(a_prod_reg[1])
                  + SUM_WIDTH'(a_prod_reg[2]);
        b_flags_next.last = a_flags_reg.last;
        b_flags_next.vis  = a_flags_reg.vis && !plane_sum[SUM_WIDTH-1];
    end

    // Test stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && b_ready)
        begin
            b_lo_reg    <= a_lo_reg;
            b_hi_reg    <= a_hi_reg;
            b_flags_reg <= b_flags_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_lo    = b_lo_reg;
    assign out_hi    = b_hi_reg;
    assign out_flags = b_flags_reg;

endmodule : fac_cell

`default_nettype wire

// ===== design/fac_tally.sv =====
// Batch counters and the result register at the end of the cell chain.
`default_nettype none

module fac_tally
    import fac_pkg::*;
#(
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire fac_flags_t             in_flags,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [INDEX_WIDTH-1:0]      box_index,
    output logic                        visible,
    output logic [INDEX_WIDTH:0]        visible_count,
    output logic                        batch_end
);

    localparam logic [INDEX_WIDTH-1:0] IDX_MAX = '1;
    localparam logic [INDEX_WIDTH:0]   CNT_MAX = {1'b1, {INDEX_WIDTH{1'b0}}};

    logic [INDEX_WIDTH-1:0] index_reg;
    logic [INDEX_WIDTH-1:0] index_next;
    logic [INDEX_WIDTH:0]   total_reg;
    logic [INDEX_WIDTH:0]   total_next;
    logic [INDEX_WIDTH:0]   count_sat;
    logic                   take;

    logic                   out_valid_reg;
    logic [INDEX_WIDTH-1:0] box_index_reg;
    logic                   visible_reg;
    logic [INDEX_WIDTH:0]   visible_count_reg;
    logic                   batch_end_reg;

    // The result register frees up when it is empty or its beat is taken.
    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // Saturating index and count; both restart after the last box.
    always_comb
    begin
        count_sat = (in_flags.vis && (total_reg != CNT_MAX)) ? total_reg + 1'b1 : total_reg;
        if (!take)
        begin
            index_next = index_reg;
            total_next = total_reg;
        end
        else if (in_flags.last)
        begin
            index_next = '0;
            total_next = '0;
        end
        else
        begin
            index_next = (index_reg != IDX_MAX) ? index_reg + 1'b1 : index_reg;
            total_next = count_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            index_reg <= index_next;
            total_reg <= total_next;
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            box_index_reg     <= index_reg;
            visible_reg       <= in_flags.vis;
            visible_count_reg <= count_sat;
            batch_end_reg     <= in_flags.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign box_index     = box_index_reg;
    assign visible       = visible_reg;
    assign visible_count = visible_count_reg;
    assign batch_end     = batch_end_reg;

endmodule : fac_tally

`default_nettype wire

// ===== design/frustum_aabb_cull.sv =====
// Top level of the frustum box culler: plane registers, cell chain and tally.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data      | in
//   box     | in_valid, in_ready, min_*/max_*, last_box      | in
//   result  | out_valid, out_ready, box_index, visible,      | out
//           | visible_count, batch_end                       |
//
// One box per cycle enters and one result per cycle leaves while out_ready is
// high; each plane cell has a product stage and a test stage, and the tally
// adds a result register. Reset clears the planes to zero (no box culled)
// and both batch counters. When out_ready is low the chain keeps taking beats
// until every stage is full; cfg_ready is always high.
`default_nettype none

module frustum_aabb_cull
    import fac_pkg::*;
#(
    parameter int PLANE_COUNT = PLANE_COUNT_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  wire logic [PLANE_WIDTH-1:0]        cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] min_x,
    input  wire logic signed [COORD_WIDTH-1:0] min_y,
    input  wire logic signed [COORD_WIDTH-1:0] min_z,
    input  wire logic signed [COORD_WIDTH-1:0] max_x,
    input  wire logic signed [COORD_WIDTH-1:0] max_y,
    input  wire logic signed [COORD_WIDTH-1:0] max_z,
    input  wire logic                          last_box,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [INDEX_WIDTH-1:0]             box_index,
    output logic                               visible,
    output logic [INDEX_WIDTH:0]               visible_count,
    output logic                               batch_end
);

    logic [PLANE_WIDTH-1:0]   plane_word  [PLANE_COUNT];
    logic                     chain_valid [PLANE_COUNT+1];
    logic                     chain_ready [PLANE_COUNT+1];
    logic [3*COORD_WIDTH-1:0] chain_lo    [PLANE_COUNT+1];
    logic [3*COORD_WIDTH-1:0] chain_hi    [PLANE_COUNT+1];
    fac_flags_t               chain_flags [PLANE_COUNT+1];

    // Configuration writes are always taken; indexes past the list are dropped.
    assign cfg_ready = 1'b1;

    // Plane registers; planes past the writable set stay zero and never cull.
    for (genvar p = 0; p < PLANE_COUNT; p++)
    begin : g_plane
        if (p < REG_COUNT)
        begin : g_reg
            logic [PLANE_WIDTH-1:0] plane_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    plane_reg <= '0;
                end
                else if (cfg_valid && cfg_ready && (cfg_index == CFG_INDEX_WIDTH'(p)))
                begin
                    plane_reg <= cfg_data;
                end
            end

            assign plane_word[p] = plane_reg;
        end
        else
        begin : g_zero
            assign plane_word[p] = '0;
        end
    end

    // Head of the chain: a box starts out visible.
    assign chain_valid[0]      = in_valid;
    assign in_ready            = chain_ready[0];
    assign chain_lo[0]         = {min_z, min_y, min_x};
    assign chain_hi[0]         = {max_z, max_y, max_x};
    assign chain_flags[0].last = last_box;
    assign chain_flags[0].vis  = 1'b1;

    // One cell per plane, each passing its beat to the next.
    for (genvar p = 0; p < PLANE_COUNT; p++)
    begin : g_cell
        fac_cell #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .plane     (plane_word[p]),
            .in_valid  (chain_valid[p]),
            .in_ready  (chain_ready[p]),
            .in_lo     (chain_lo[p]),
            .in_hi     (chain_hi[p]),
            .in_flags  (chain_flags[p]),
            .out_valid (chain_valid[p+1]),
            .out_ready (chain_ready[p+1]),
            .out_lo    (chain_lo[p+1]),
            .out_hi    (chain_hi[p+1]),
            .out_flags (chain_flags[p+1])
        );
    end

    // Counters and the result register.
    fac_tally #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_tally (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (chain_valid[PLANE_COUNT]),
        .in_ready      (chain_ready[PLANE_COUNT]),
        .in_flags      (chain_flags[PLANE_COUNT]),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .box_index     (box_index),
        .visible       (visible),
        .visible_count (visible_count),
        .batch_end     (batch_end)
    );

endmodule : frustum_aabb_cull

`default_nettype wire

// ===== design/fac_checker.sv =====
// Port-level checks on the result stream of the culler, bound to the top level.
`default_nettype none

module fac_checker
    import fac_pkg::*;
#(
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   out_valid,
    input  wire logic                   out_ready,
    input  wire logic [INDEX_WIDTH-1:0] box_index,
    input  wire logic                   visible,
    input  wire logic [INDEX_WIDTH:0]   visible_count,
    input  wire logic                   batch_end
);

    localparam logic [INDEX_WIDTH-1:0] IDX_MAX = '1;
    localparam logic [INDEX_WIDTH:0]   CNT_MAX = {1'b1, {INDEX_WIDTH{1'b0}}};

    logic                   at_start_reg;
    logic [INDEX_WIDTH-1:0] prev_idx_reg;
    logic [INDEX_WIDTH:0]   prev_cnt_reg;
    logic [INDEX_WIDTH-1:0] exp_idx;
    logic [INDEX_WIDTH:0]   exp_cnt;
    logic [INDEX_WIDTH:0]   first_cnt;

    // Track the last delivered result and whether a new batch begins.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg <= 1'b1;
            prev_idx_reg <= '0;
            prev_cnt_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            at_start_reg <= batch_end;
            prev_idx_reg <= box_index;
            prev_cnt_reg <= visible_count;
        end
    end

    // Expected values for a result that continues a batch.
    always_comb
    begin
        exp_idx   = (prev_idx_reg != IDX_MAX) ? prev_idx_reg + 1'b1 : prev_idx_reg;
        exp_cnt   = (visible && (prev_cnt_reg != CNT_MAX)) ? prev_cnt_reg + 1'b1 : prev_cnt_reg;
        first_cnt = {{INDEX_WIDTH{1'b0}}, visible};
    end

    // A stalled result beat holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(box_index)
            && $stable(visible) && $stable(visible_count) && $stable(batch_end))
        else $error("result beat changed while stalled");

    // The first result of a batch starts both counters afresh.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && at_start_reg |-> box_index == '0 && visible_count == first_cnt)
        else $error("batch did not restart its counters");

    // Inside a batch the index steps by one and saturates.
    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !at_start_reg |-> box_index == exp_idx)
        else $error("box index out of sequence");

    // Inside a batch the count grows only with visible boxes and saturates.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !at_start_reg |-> visible_count == exp_cnt)
        else $error("visible count out of sequence");

endmodule : fac_checker

bind frustum_aabb_cull fac_checker #(
    .INDEX_WIDTH (INDEX_WIDTH)
) u_fac_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .box_index     (box_index),
    .visible       (visible),
    .visible_count (visible_count),
    .batch_end     (batch_end)
);

`default_nettype wire
